### hw/rtl/vca_pkg.sv
// Package for the voice channel allocator: shared types and fixed constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package vca_pkg;

  localparam int CHAN_W  = 7;   // channel number width
  localparam int SLOT_W  = 4;   // slot index within a row (row stride of 16)
  localparam int ROW_W   = 3;   // instrument / row index width
  localparam int NUM_ROWS = 8;  // rows addressable by the instrument field
  localparam int MAP_W   = 8;   // note map entry width
  localparam int NOTE_W  = 7;

  localparam logic [MAP_W-1:0] FAIL_MARK = 8'hFF;

  typedef enum logic {
    OP_PLAY = 1'b0,
    OP_STOP = 1'b1
  } op_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              ok;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/vca_map.sv
// Note-to-channel map memory with registered read and a clearing pass after reset.
// Depends on vca_pkg for the entry width.
`default_nettype none

module vca_map #(
  parameter int DEPTH = 896,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [vca_pkg::MAP_W-1:0]  rd_data,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [vca_pkg::MAP_W-1:0]  wr_data,
  output logic                            map_ready
);
  import vca_pkg::*;

  logic [MAP_W-1:0] mem [DEPTH];
  logic [MAP_W-1:0] rd_data_r;
  logic [AW-1:0]    clr_idx_r;
  logic             clr_busy_r;

  // Sweep every entry to channel 0 after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign map_ready = !clr_busy_r;

endmodule

`default_nettype wire

### hw/rtl/vca_busy.sv
// Busy-bit rows, first-free slot search and result/map-update decode for one item.
// Depends on vca_pkg for op codes, result struct and constants.
`default_nettype none

module vca_busy #(
  parameter int SLOTS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         commit,
  input  wire vca_pkg::op_t                 op,
  input  wire logic [vca_pkg::ROW_W-1:0]    instrument,
  input  wire logic                         item_ok,
  input  wire logic [vca_pkg::MAP_W-1:0]    entry,
  output vca_pkg::res_t                     res,
  output logic                              map_we,
  output logic      [vca_pkg::MAP_W-1:0]    map_wdata
);
  import vca_pkg::*;

  logic [SLOTS-1:0]  busy_r [NUM_ROWS];
  logic [ROW_W-1:0]  row_sel;
  logic [SLOTS-1:0]  row;
  logic [SLOTS-1:0]  row_nxt;
  logic [SLOTS-1:0]  set_mask;
  logic [SLOTS-1:0]  clr_mask;
  logic [SLOT_W-1:0] slot;
  logic              found;
  logic              row_we;

  // Stop works on the row recorded in the map entry, play on its own row.
  assign row_sel = (op == OP_STOP) ? entry[CHAN_W-1:SLOT_W] : instrument;
  assign row     = busy_r[row_sel];

  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!row[s]) begin
        found = 1'b1;
        slot  = SLOT_W'(s);
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      set_mask[s] = (slot == SLOT_W'(s));
      clr_mask[s] = (entry[SLOT_W-1:0] == SLOT_W'(s));
    end
  end

  always_comb begin
    res       = '0;
    map_we    = 1'b0;
    map_wdata = '0;
    row_we    = 1'b0;
    row_nxt   = row;
    if (item_ok) begin
      unique case (op)
        OP_PLAY: begin
          map_we = commit;
          if (found) begin
            row_nxt     = row | set_mask;
            row_we      = 1'b1;
            res.channel = {instrument, slot};
            res.ok      = 1'b1;
            map_wdata   = {1'b0, instrument, slot};
          end else begin
            map_wdata = FAIL_MARK;
          end
        end
        OP_STOP: begin
          if (entry != FAIL_MARK) begin
            row_nxt     = row & ~clr_mask;
            row_we      = 1'b1;
            res.channel = entry[CHAN_W-1:0];
            res.ok      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        busy_r[r] <= '0;
      end
    end else if (commit && row_we) begin
      busy_r[row_sel] <= row_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/voice_channel_allocator.sv
// Voice channel allocator top level: input stage, map read forwarding, result register.
// Depends on vca_pkg, vca_map and vca_busy.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: in_op play or stop,
//   in_instrument and in_note. Result channel (out_valid/out_ready) returns one
//   transaction per request: out_channel and out_ok, in request order.
//   The note-map read is registered at the acceptance edge, next to the input
//   stage; the busy-row update and the result register are written when the
//   item leaves the input stage, which waits while a held result is not taken.
//   One request is accepted every cycle while the result channel does not
//   stall; a map write from the item ahead is forwarded to a following read
//   of the same entry.
//   After reset the note map is swept to channel 0, one entry per cycle, over
//   all NUM_INSTRUMENTS * NUM_NOTES entries (896 at the defaults); in_ready stays
//   low until the sweep is done. Busy rows clear at once.
//   When the receiver stalls, the result register holds; the input stage
//   still takes one more request, then in_ready drops until out_ready returns.
`default_nettype none

module voice_channel_allocator #(
  parameter int SLOTS_PER_INSTRUMENT = 16,
  parameter int NUM_INSTRUMENTS      = 7,
  parameter int NUM_NOTES            = 128
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_op,
  input  wire logic [vca_pkg::ROW_W-1:0]    in_instrument,
  input  wire logic [vca_pkg::NOTE_W-1:0]   in_note,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [vca_pkg::CHAN_W-1:0]   out_channel,
  output logic                              out_ok
);
  import vca_pkg::*;

  localparam int MAP_DEPTH = NUM_INSTRUMENTS * NUM_NOTES;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  logic             accept;
  logic             s1_go;
  logic             map_ready;
  logic             in_item_ok;
  logic [AW-1:0]    in_addr;
  logic [MAP_W-1:0] map_rd_data;
  logic [MAP_W-1:0] entry;
  logic             map_we;
  logic [MAP_W-1:0] map_wdata;
  res_t             res;

  logic             s1_valid_r;
  op_t              s1_op_r;
  logic [ROW_W-1:0] s1_instr_r;
  logic             s1_ok_r;
  logic [AW-1:0]    s1_addr_r;
  logic             fwd_hit_r;
  logic [MAP_W-1:0] fwd_data_r;
  logic             fwd_hit_nxt;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_channel_r;
  logic              out_ok_r;

  assign in_item_ok = (in_instrument != '0) &&
                      (in_instrument <= ROW_W'(NUM_INSTRUMENTS)) &&
                      ({1'b0, in_note} < (NOTE_W + 1)'(NUM_NOTES));
  assign in_addr    = AW'((32'(in_instrument) - 32'd1) * NUM_NOTES + 32'(in_note));

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = map_ready && (!s1_valid_r || s1_go);
  assign accept   = in_valid && in_ready;

  // The item leaving the stage writes the map at the same edge this read is taken.
  assign fwd_hit_nxt = s1_go && map_we && (s1_addr_r == in_addr);
  assign entry       = fwd_hit_r ? fwd_data_r : map_rd_data;

  vca_map #(
    .DEPTH (MAP_DEPTH),
    .AW    (AW)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept && in_item_ok),
    .rd_addr   (in_addr),
    .rd_data   (map_rd_data),
    .wr_en     (map_we),
    .wr_addr   (s1_addr_r),
    .wr_data   (map_wdata),
    .map_ready (map_ready)
  );

  vca_busy #(
    .SLOTS (SLOTS_PER_INSTRUMENT)
  ) u_busy (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (s1_go),
    .op         (s1_op_r),
    .instrument (s1_instr_r),
    .item_ok    (s1_ok_r),
    .entry      (entry),
    .res        (res),
    .map_we     (map_we),
    .map_wdata  (map_wdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_t'(in_op);
      s1_instr_r <= in_instrument;
      s1_ok_r    <= in_item_ok;
      s1_addr_r  <= in_addr;
      fwd_hit_r  <= fwd_hit_nxt;
      fwd_data_r <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_channel_r <= res.channel;
      out_ok_r      <= res.ok;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_ok      = out_ok_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !map_ready |-> !in_ready)
    else $error("request taken during map clear");

  a_fail_zero_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_channel_r == '0))
    else $error("failed transaction carries a nonzero channel");

  a_play_row_match: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_op_r == OP_PLAY && res.ok) |-> (res.channel[CHAN_W-1:SLOT_W] == s1_instr_r))
    else $error("allocated channel outside the instrument row");

  a_commit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("committed item did not reach the result register");

  a_fwd_only_play: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fwd_hit_nxt) |-> (s1_op_r == OP_PLAY && s1_ok_r))
    else $error("forwarding from an item that does not write the map");

endmodule

`default_nettype wire
